// ----- src/lidar_column_ground_classifier_unit_defines.svh -----
// Assertion helpers for the column ground classifier.
`ifndef LIDAR_COLUMN_GROUND_CLASSIFIER_UNIT_DEFINES_SVH
`define LIDAR_COLUMN_GROUND_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCGC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lcgc_pkg.sv -----
package lcgc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_GROUND_HEIGHT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_GAP          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_HEIGHT_CAP = 2'd3;

  // register widths
  localparam int GH_W     = 21;
  localparam int RISE_W   = 16;
  localparam int GAP_W    = 20;
  localparam int GAP_SQ_W = 2 * GAP_W;
  localparam int CAP_W    = 21;

  // reset values
  localparam logic signed [GH_W-1:0]  GH_RST     = -21'sd6400;
  localparam logic [RISE_W-1:0]       RISE_RST   = 16'd10;
  localparam logic [GAP_SQ_W-1:0]     GAP_SQ_RST = 40'd4000000;  // 2000 squared
  localparam logic signed [CAP_W-1:0] CAP_RST    = 21'sd4000;

  // height and step tests settled in the product stage
  typedef struct packed {
    logic start;
    logic le_gh;      // z at or below ground height
    logic rise_gh;    // z - ground height above rise threshold
    logic rise_prev;  // z - previous z above rise threshold
    logic z_gt_prev;
    logic z_lt_prev;
    logic moved;      // planar step nonzero
    logic le_cap;     // z at or below object height cap
  } p_flags_t;

endpackage

// ----- src/lidar_column_ground_classifier_unit.sv -----
// Lidar column ground classifier.
// Input channel: one point per request (x, y, z in 0.25 mm units, COORD_WIDTH
// bits signed) with column_start set on the first point of each column.
// Result channel: one request per point, ground flag and near_object.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata),
// to be used only while no point is in flight.
// A point passes through three register stages in order (input, squares,
// result); one point per cycle is accepted while the result channel is not
// stalled.
// Loop-carried state is the previous point's coordinates, label and range;
// label and range are set by the final stage in the same cycle they are used.
// Reset (synchronous, rst_n low): pipeline emptied, registers to defaults,
// previous point set to the origin and labelled ground.
// Receiver stall: the result register holds its request; points keep flowing
// into empty stages behind it, so up to three points sit inside before
// in_stall rises.
module lidar_column_ground_classifier_unit #(
  parameter int COORD_WIDTH = 21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_z,
  input  logic                              in_column_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ground,
  output logic                              out_near_object,
  input  logic                              cfg_we,
  input  logic [lcgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcgc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lcgc_pkg::*;

  localparam int CW    = COORD_WIDTH;
  // height compare width: covers coordinate and register ranges plus a sign
  localparam int ZW    = ((CW > GH_W) ? CW : GH_W) + 2;
  localparam int PW    = 2 * CW + 2;               // full signed product
  localparam int SQW   = 2 * CW;                   // one square
  localparam int RSW   = 2 * CW + 1;               // sum of two squares
  localparam int DSW   = (RSW > GAP_SQ_W) ? RSW : GAP_SQ_W;

  // ---------------- configuration ----------------
  logic signed [GH_W-1:0]  gh_r;
  logic [RISE_W-1:0]       rise_r;
  logic [GAP_SQ_W-1:0]     gap_sq_r;
  logic signed [CAP_W-1:0] cap_r;
  logic [GAP_SQ_W-1:0]     gap_sq_nxt;

  // near_gap is only ever used squared, so square it on the write
  assign gap_sq_nxt = GAP_SQ_W'(cfg_wdata[GAP_W-1:0]) * GAP_SQ_W'(cfg_wdata[GAP_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gh_r     <= GH_RST;
      rise_r   <= RISE_RST;
      gap_sq_r <= GAP_SQ_RST;
      cap_r    <= CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROUND_HEIGHT:     gh_r     <= cfg_wdata[GH_W-1:0];
        REG_RISE_THRESHOLD:    rise_r   <= cfg_wdata[RISE_W-1:0];
        REG_NEAR_GAP:          gap_sq_r <= gap_sq_nxt;
        REG_OBJECT_HEIGHT_CAP: cap_r    <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage control ----------------
  // Each stage loads when empty or when it is handing its request on.
  logic s1_v_r, p_v_r, out_v_r;
  logic out_ld, p_ld, s1_ld;

  assign out_ld   = !out_v_r || !out_stall;
  assign p_ld     = !p_v_r || out_ld;
  assign s1_ld    = !s1_v_r || p_ld;
  assign in_stall = !s1_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ld)  s1_v_r  <= in_valid;
      if (p_ld)   p_v_r   <= s1_v_r;
      if (out_ld) out_v_r <= p_v_r;
    end
  end

  // ---------------- input register ----------------
  logic signed [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic                 s1_start_r;

  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) begin
      s1_x_r     <= in_pos_x;
      s1_y_r     <= in_pos_y;
      s1_z_r     <= in_pos_z;
      s1_start_r <= in_column_start;
    end
  end

  // ---------------- product stage ----------------
  // Previous coordinates follow input order and do not depend on the label,
  // so they advance as a point leaves the input register.
  logic signed [CW-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                 s1_go;

  assign s1_go = s1_v_r && p_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_z_r <= '0;
    end else if (s1_go) begin
      prev_x_r <= s1_x_r;
      prev_y_r <= s1_y_r;
      prev_z_r <= s1_z_r;
    end
  end

  logic signed [CW:0]   dx, dy;
  logic signed [PW-1:0] xsq_full, ysq_full, dxsq_full, dysq_full;
  logic signed [ZW-1:0] z_e, pz_e, gh_e, cap_e, rise_e;
  p_flags_t             flags_nxt;

  assign dx = {s1_x_r[CW-1], s1_x_r} - {prev_x_r[CW-1], prev_x_r};
  assign dy = {s1_y_r[CW-1], s1_y_r} - {prev_y_r[CW-1], prev_y_r};

  // signed squares are never negative, so the low bits hold the magnitude
  assign xsq_full  = s1_x_r * s1_x_r;
  assign ysq_full  = s1_y_r * s1_y_r;
  assign dxsq_full = dx * dx;
  assign dysq_full = dy * dy;

  assign z_e    = {{(ZW-CW){s1_z_r[CW-1]}}, s1_z_r};
  assign pz_e   = {{(ZW-CW){prev_z_r[CW-1]}}, prev_z_r};
  assign gh_e   = {{(ZW-GH_W){gh_r[GH_W-1]}}, gh_r};
  assign cap_e  = {{(ZW-CAP_W){cap_r[CAP_W-1]}}, cap_r};
  assign rise_e = {{(ZW-RISE_W){1'b0}}, rise_r};

  always_comb begin
    flags_nxt.start     = s1_start_r;
    flags_nxt.le_gh     = z_e <= gh_e;
    flags_nxt.rise_gh   = (z_e - gh_e) > rise_e;
    flags_nxt.rise_prev = (z_e - pz_e) > rise_e;
    flags_nxt.z_gt_prev = z_e > pz_e;
    flags_nxt.z_lt_prev = z_e < pz_e;
    flags_nxt.moved     = (s1_x_r != prev_x_r) || (s1_y_r != prev_y_r);
    flags_nxt.le_cap    = z_e <= cap_e;
  end

  logic [SQW-1:0] p_xsq_r, p_ysq_r, p_dxsq_r, p_dysq_r;
  p_flags_t       p_flags_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      p_xsq_r   <= xsq_full[SQW-1:0];
      p_ysq_r   <= ysq_full[SQW-1:0];
      p_dxsq_r  <= dxsq_full[SQW-1:0];
      p_dysq_r  <= dysq_full[SQW-1:0];
      p_flags_r <= flags_nxt;
    end
  end

  // ---------------- decision stage ----------------
  // Label and range of the last classified point feed straight back here.
  logic [RSW-1:0] rsq, prev_rsq_r;
  logic [DSW-1:0] dsq, gap_sq_e;
  logic           prev_ground_r;
  logic           ground_nxt, near_nxt, p_go;

  assign rsq      = RSW'(p_xsq_r) + RSW'(p_ysq_r);
  assign dsq      = DSW'(p_dxsq_r) + DSW'(p_dysq_r);
  assign gap_sq_e = DSW'(gap_sq_r);
  assign p_go     = p_v_r && out_ld;

  always_comb begin
    if (p_flags_r.le_gh) begin
      ground_nxt = 1'b1;
    end else if (p_flags_r.start) begin
      // first point of a column: measured against the ground reference
      ground_nxt = !(p_flags_r.rise_gh && (rsq != '0));
    end else if (rsq <= prev_rsq_r) begin
      ground_nxt = 1'b0;
    end else if (prev_ground_r) begin
      ground_nxt = !(p_flags_r.rise_prev && p_flags_r.moved);
    end else if (p_flags_r.z_gt_prev && (dsq < gap_sq_e)) begin
      ground_nxt = 1'b0;
    end else begin
      ground_nxt = p_flags_r.z_lt_prev && p_flags_r.moved;
    end
    near_nxt = !ground_nxt && p_flags_r.le_cap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_rsq_r    <= '0;
      prev_ground_r <= 1'b1;
    end else if (p_go) begin
      prev_rsq_r    <= rsq;
      prev_ground_r <= ground_nxt;
    end
  end

  // ---------------- result register ----------------
  logic out_ground_r, out_near_r;

  always_ff @(posedge clk) begin
    if (p_go) begin
      out_ground_r <= ground_nxt;
      out_near_r   <= near_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_ground      = out_ground_r;
  assign out_near_object = out_near_r;

endmodule

// ----- src/lcgc_checker.sv -----
`include "lidar_column_ground_classifier_unit_defines.svh"

module lcgc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_ground,
  input logic out_near_object
);

  // a stalled result holds
  `LCGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_ground) && $stable(out_near_object), "stalled result changed")

  // near_object only on object points
  `LCGC_ASSERT_IMPL(a_near_is_object, clk, rst_n, out_valid, !(out_ground && out_near_object), "near_object on a ground point")

  // with no result waiting the input side must be open
  `LCGC_ASSERT_IMPL(a_no_false_stall, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")

  // a request taken with a free output path shows up as a valid result
  `LCGC_ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid, "result missing after two cycles")

endmodule

bind lidar_column_ground_classifier_unit lcgc_checker u_lcgc_checker (.*);
